@@ hw/rtl/spa_pkg.sv @@
// Shared types and constants of the sparse polynomial adder.
package spa_pkg;

    localparam int TERMS_EACH_DEF = 32;
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_ADD    = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_ADD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic signed [15:0] coef;
        logic [15:0]        expon;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] coef;
        logic [15:0]        expon;
    } term_t;

    typedef struct packed {
        logic signed [15:0] coef;
        logic [15:0]        expon;
        logic               last_term;
        logic               zero_poly;
        logic               terms_lost;
    } res_t;

endpackage

@@ hw/rtl/sparse_polynomial_adder.sv @@
// Top level of the sparse polynomial adder.
// Items enter a four-entry command queue and are accepted whenever full is low; an item
// with action 3 is accepted and ignored. The back end takes one command per cycle while
// idle: a load writes one term into store A or B, or flags terms lost if that store is
// full. An add primes the store read ports as it is taken, merges over the store heads
// and flushes the final term, and no further command is taken until it finishes.
// Results leave through a four-entry result queue; a full result queue holds the merge.
module sparse_polynomial_adder #(
    parameter int TERMS_EACH = spa_pkg::TERMS_EACH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic signed [15:0] coef_in,
    input  logic [15:0]        expon_in,
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] coef_out,
    output logic [15:0]        expon_out,
    output logic               last_term,
    output logic               zero_poly,
    output logic               terms_lost
);

    import spa_pkg::*;

    cmd_t cmd;
    logic cmd_pop;
    logic cmd_empty;
    res_t res;

    spa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .coef_in   (coef_in),
        .expon_in  (expon_in),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    spa_back #(
        .TERMS_EACH (TERMS_EACH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign coef_out   = res.coef;
    assign expon_out  = res.expon;
    assign last_term  = res.last_term;
    assign zero_poly  = res.zero_poly;
    assign terms_lost = res.terms_lost;

endmodule

@@ hw/rtl/spa_queue.sv @@
// Small first-in first-out queue of fixed-width items.
module spa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == NW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ hw/rtl/spa_front.sv @@
// Front end: accepts input items, decodes the action and queues commands.
module spa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    action,
    input  logic signed [15:0] coef_in,
    input  logic [15:0]   expon_in,
    input  logic          cmd_pop,
    output logic          cmd_empty,
    output spa_pkg::cmd_t cmd
);

    import spa_pkg::*;

    cmd_t cmd_in;
    logic cmd_push;

    always_comb
    begin
        cmd_in.coef  = coef_in;
        cmd_in.expon = expon_in;
        cmd_in.op    = CMD_ADD;
        cmd_push     = 1'b0;
        unique case (action)
            ACT_LOAD_A:
            begin
                cmd_in.op = CMD_LOAD_A;
                cmd_push  = push;
            end
            ACT_LOAD_B:
            begin
                cmd_in.op = CMD_LOAD_B;
                cmd_push  = push;
            end
            ACT_ADD:
            begin
                cmd_in.op = CMD_ADD;
                cmd_push  = push;
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    spa_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmd_empty)
    );

endmodule

@@ hw/rtl/spa_back.sv @@
// Back end: term stores, merge sequencer and result queue.
module spa_back #(
    parameter int TERMS_EACH = spa_pkg::TERMS_EACH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  spa_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output spa_pkg::res_t res
);

    import spa_pkg::*;

    localparam int CW = $clog2(TERMS_EACH + 1);
    localparam int AW = (TERMS_EACH > 1) ? $clog2(TERMS_EACH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t  state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] ib_reg, ib_next;
    logic    lost_reg, lost_next;
    term_t   pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;

    term_t   a_mem [TERMS_EACH];
    term_t   b_mem [TERMS_EACH];
    term_t   a_rd_reg, b_rd_reg;
    logic    a_we, b_we;
    term_t   wr_term;

    logic    a_avail, b_avail;
    logic    take_a, take_b;
    logic    term_ok;
    term_t   term;
    logic signed [16:0] sum;
    logic signed [15:0] sat;

    logic    res_push, res_full;
    res_t    res_item;

    always_comb
    begin
        sum = {a_rd_reg.coef[15], a_rd_reg.coef} + {b_rd_reg.coef[15], b_rd_reg.coef};
        if (sum[16] != sum[15])
        begin
            sat = sum[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        lost_next       = lost_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_pop         = 1'b0;
        a_we            = 1'b0;
        b_we            = 1'b0;
        wr_term.coef    = cmd.coef;
        wr_term.expon   = cmd.expon;
        res_push        = 1'b0;
        res_item        = '0;
        a_avail         = (ia_reg < count_a_reg);
        b_avail         = (ib_reg < count_b_reg);
        take_a          = 1'b0;
        take_b          = 1'b0;
        term_ok         = 1'b0;
        term            = a_rd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        CMD_LOAD_A:
                        begin
                            if (count_a_reg < CW'(TERMS_EACH))
                            begin
                                a_we         = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (count_b_reg < CW'(TERMS_EACH))
                            begin
                                b_we         = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        CMD_ADD:
                        begin
                            state_next      = ST_MERGE;
                            ia_next         = '0;
                            ib_next         = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (!res_full)
                begin
                    if (!a_avail && !b_avail)
                    begin
                        res_push            = 1'b1;
                        res_item.terms_lost = lost_reg;
                        res_item.last_term  = 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_item.coef  = pend_reg.coef;
                            res_item.expon = pend_reg.expon;
                        end
                        else
                        begin
                            res_item.zero_poly = 1'b1;
                        end
                        pend_valid_next = 1'b0;
                        count_a_next    = '0;
                        count_b_next    = '0;
                        lost_next       = 1'b0;
                        ia_next         = '0;
                        ib_next         = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        if (a_avail && b_avail)
                        begin
                            if (a_rd_reg.expon > b_rd_reg.expon)
                            begin
                                take_a = 1'b1;
                            end
                            else if (a_rd_reg.expon < b_rd_reg.expon)
                            begin
                                take_b = 1'b1;
                            end
                            else
                            begin
                                take_a = 1'b1;
                                take_b = 1'b1;
                            end
                        end
                        else if (a_avail)
                        begin
                            take_a = 1'b1;
                        end
                        else
                        begin
                            take_b = 1'b1;
                        end

                        if (take_a && take_b)
                        begin
                            term.coef  = sat;
                            term.expon = a_rd_reg.expon;
                            term_ok    = (sat != 16'sd0);
                        end
                        else if (take_a)
                        begin
                            term    = a_rd_reg;
                            term_ok = 1'b1;
                        end
                        else
                        begin
                            term    = b_rd_reg;
                            term_ok = 1'b1;
                        end

                        if (term_ok)
                        begin
                            if (pend_valid_reg)
                            begin
                                res_push            = 1'b1;
                                res_item.coef       = pend_reg.coef;
                                res_item.expon      = pend_reg.expon;
                                res_item.terms_lost = lost_reg;
                            end
                            pend_next       = term;
                            pend_valid_next = 1'b1;
                        end
                        ia_next = ia_reg + CW'(take_a);
                        ib_next = ib_reg + CW'(take_b);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[count_a_reg[AW-1:0]] <= wr_term;
        end
        if (b_we)
        begin
            b_mem[count_b_reg[AW-1:0]] <= wr_term;
        end
        a_rd_reg <= a_mem[ia_next[AW-1:0]];
        b_rd_reg <= b_mem[ib_next[AW-1:0]];
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            lost_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            lost_reg       <= lost_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    spa_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_item),
        .full  (res_full),
        .pop   (pop),
        .dout  (res),
        .empty (empty)
    );

`ifndef SYNTHESIS
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ia_reg <= count_a_reg) && (ib_reg <= count_b_reg))
        else $error("merge index beyond store fill");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_a_reg <= CW'(TERMS_EACH)) && (count_b_reg <= CW'(TERMS_EACH)))
        else $error("store fill beyond capacity");

    a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_item.zero_poly) |-> res_item.last_term)
        else $error("empty-sum item not marked last");

    a_stores_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE && state_next == ST_IDLE) |=>
        (count_a_reg == '0 && count_b_reg == '0 && !lost_reg && !pend_valid_reg))
        else $error("stores not emptied after add");

    a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (!cmd_pop && !a_we && !b_we))
        else $error("command taken during merge");
`endif

endmodule

@@ tb/tb_sparse_polynomial_adder.sv @@
// Testbench for the sparse polynomial adder: directed and random term streams.
`timescale 1ns / 1ps

module tb_sparse_polynomial_adder;
    import spa_pkg::*;

    localparam int STORE_DEPTH = TERMS_EACH_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         action;
    logic signed [15:0] coef_in;
    logic [15:0]        expon_in;
    logic               pop;
    logic               empty;
    logic signed [15:0] coef_out;
    logic [15:0]        expon_out;
    logic               last_term;
    logic               zero_poly;
    logic               terms_lost;

    logic signed [15:0] held_a_coef [STORE_DEPTH];
    logic [15:0]        held_a_expon [STORE_DEPTH];
    logic signed [15:0] held_b_coef [STORE_DEPTH];
    logic [15:0]        held_b_expon [STORE_DEPTH];
    int                 held_a;
    int                 held_b;
    bit                 lost_loads;

    res_t sum_build[$];
    res_t sum_due[$];

    int fails;
    bit no_gaps;
    int rx_hold_req;

    sparse_polynomial_adder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .coef_in    (coef_in),
        .expon_in   (expon_in),
        .pop        (pop),
        .empty      (empty),
        .coef_out   (coef_out),
        .expon_out  (expon_out),
        .last_term  (last_term),
        .zero_poly  (zero_poly),
        .terms_lost (terms_lost)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void add_sum_term(logic signed [15:0] c, logic [15:0] e);
        res_t r;
        r.coef = c;
        r.expon = e;
        r.last_term = 1'b0;
        r.zero_poly = 1'b0;
        r.terms_lost = lost_loads;
        sum_build.push_back(r);
    endfunction

    function automatic void merge_stores();
        int   ia;
        int   ib;
        int   s;
        int   i;
        bit   empty_sum;
        res_t r;
        ia = 0;
        ib = 0;
        sum_build.delete();
        while (ia < held_a && ib < held_b)
        begin
            if (held_a_expon[ia] < held_b_expon[ib])
            begin
                add_sum_term(held_b_coef[ib], held_b_expon[ib]);
                ib++;
            end
            else if (held_a_expon[ia] > held_b_expon[ib])
            begin
                add_sum_term(held_a_coef[ia], held_a_expon[ia]);
                ia++;
            end
            else
            begin
                s = int'(held_a_coef[ia]) + int'(held_b_coef[ib]);
                if (s > 32767)
                    s = 32767;
                if (s < -32768)
                    s = -32768;
                if (s != 0)
                    add_sum_term(s[15:0], held_a_expon[ia]);
                ia++;
                ib++;
            end
        end
        for (; ia < held_a; ia++)
            add_sum_term(held_a_coef[ia], held_a_expon[ia]);
        for (; ib < held_b; ib++)
            add_sum_term(held_b_coef[ib], held_b_expon[ib]);
        empty_sum = (sum_build.size() == 0);
        if (empty_sum)
            add_sum_term(16'sd0, 16'd0);
        for (i = 0; i < sum_build.size(); i++)
        begin
            r = sum_build[i];
            r.last_term = (i == sum_build.size() - 1);
            r.zero_poly = empty_sum;
            sum_due.push_back(r);
        end
        held_a = 0;
        held_b = 0;
        lost_loads = 1'b0;
    endfunction

    function automatic void predict_item(logic [1:0] act, logic signed [15:0] c,
                                         logic [15:0] e);
        case (act)
            ACT_LOAD_A:
                if (held_a < STORE_DEPTH)
                begin
                    held_a_coef[held_a] = c;
                    held_a_expon[held_a] = e;
                    held_a++;
                end
                else
                    lost_loads = 1'b1;
            ACT_LOAD_B:
                if (held_b < STORE_DEPTH)
                begin
                    held_b_coef[held_b] = c;
                    held_b_expon[held_b] = e;
                    held_b++;
                end
                else
                    lost_loads = 1'b1;
            ACT_ADD:
                merge_stores();
            default:
                ;
        endcase
    endfunction

    task automatic flag_error(input string msg);
        fails++;
        if (fails <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
            flag_error($sformatf("%s expected %0d got %0d", field, want, got));
    endtask

    task automatic send_item(input logic [1:0] act, input logic signed [15:0] c,
                             input logic [15:0] e);
        while (!no_gaps && $urandom_range(0, 99) < 16)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        action <= act;
        coef_in <= c;
        expon_in <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(act, c, e);
    endtask

    task automatic load_run(input logic [1:0] act, input int n, input int top,
                            input int stride);
        int k;
        for (k = 0; k < n; k++)
            send_item(act, 16'($urandom), 16'(top - k * stride));
    endtask

    task automatic test_corner_terms();
        send_item(ACT_ADD, 16'sd0, 16'd0);
        send_item(ACT_LOAD_A, 16'sh7FFF, 16'hFFFF);
        send_item(ACT_LOAD_A, 16'sh8000, 16'h0000);
        send_item(ACT_LOAD_B, 16'sh7FFF, 16'hFFFF);
        send_item(ACT_LOAD_B, 16'sd1, 16'd100);
        send_item(ACT_LOAD_B, 16'sh8000, 16'h0000);
        send_item(ACT_ADD, 16'shFFFF, 16'hFFFF);
        send_item(ACT_LOAD_A, 16'sd5, 16'd10);
        send_item(ACT_LOAD_B, -16'sd5, 16'd10);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        send_item(ACT_LOAD_A, 16'sd1, 16'd5);
        send_item(ACT_LOAD_A, 16'sd2, 16'd50);
        send_item(ACT_LOAD_B, 16'sd3, 16'd20);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        send_item(ACT_LOAD_A, 16'sd7, 16'd300);
        send_item(ACT_UNUSED, 16'shFFFF, 16'hFFFF);
        send_item(ACT_LOAD_B, -16'sd1, 16'd300);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        send_item(ACT_LOAD_A, 16'sd0, 16'd9);
        send_item(ACT_ADD, 16'sd0, 16'd0);
    endtask

    task automatic test_store_overflow();
        no_gaps = 1'b1;
        load_run(ACT_LOAD_A, STORE_DEPTH + 2, 65534, 2);
        load_run(ACT_LOAD_B, STORE_DEPTH + 1, 65533, 2);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold_req = 150;
        no_gaps = 1'b1;
        load_run(ACT_LOAD_A, 12, 40000, 3);
        load_run(ACT_LOAD_B, 12, 40001, 3);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        load_run(ACT_LOAD_A, 10, 500, 7);
        send_item(ACT_ADD, 16'sd0, 16'd0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_polys();
        logic signed [15:0] pa[$];
        logic signed [15:0] pb[$];
        logic [15:0]        ea[$];
        logic [15:0]        eb[$];
        logic signed [15:0] ca;
        logic signed [15:0] cb;
        logic signed [15:0] sw_c;
        logic [15:0]        sw_e;
        int                 counted;
        int                 nterms;
        int                 e;
        int                 k;
        int                 ia;
        int                 ib;
        int                 kind;
        bit                 take_a;
        counted = 0;
        while (counted < 30)
        begin
            pa.delete();
            pb.delete();
            ea.delete();
            eb.delete();
            nterms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            e = $urandom_range(0, 65535);
            for (k = 0; k < nterms; k++)
            begin
                ca = 16'($urandom);
                cb = 16'($urandom);
                case ($urandom_range(0, 9))
                    0, 1: cb = -ca;
                    2:
                    begin
                        ca = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        cb = ca[15] ? ca + 16'($urandom_range(0, 200))
                                    : ca - 16'($urandom_range(0, 200));
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        pa.push_back(ca);
                        ea.push_back(16'(e));
                    end
                    3, 4, 5:
                    begin
                        pb.push_back(cb);
                        eb.push_back(16'(e));
                    end
                    default:
                    begin
                        pa.push_back(ca);
                        ea.push_back(16'(e));
                        pb.push_back(cb);
                        eb.push_back(16'(e));
                    end
                endcase
                if (e == 0)
                    break;
                e = e - $urandom_range(1, (e < 4000) ? e : 4000);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0 && pa.size() > 1)
            begin
                sw_c = pa[0];
                sw_e = ea[0];
                pa[0] = pa[pa.size() - 1];
                ea[0] = ea[ea.size() - 1];
                pa[pa.size() - 1] = sw_c;
                ea[ea.size() - 1] = sw_e;
            end
            ia = 0;
            ib = 0;
            while (ia < pa.size() || ib < pb.size())
            begin
                if (kind == 1 && $urandom_range(0, 3) == 0)
                    send_item(ACT_UNUSED, 16'($urandom), 16'($urandom));
                take_a = (ib >= pb.size()) || (ia < pa.size() && $urandom_range(0, 1) == 1);
                if (take_a)
                begin
                    send_item(ACT_LOAD_A, pa[ia], ea[ia]);
                    ia++;
                end
                else
                begin
                    send_item(ACT_LOAD_B, pb[ib], eb[ib]);
                    ib++;
                end
                counted++;
            end
            send_item(ACT_ADD, 16'($urandom), 16'($urandom));
            counted++;
        end
    endtask

    initial
    begin : result_check
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (sum_due.size() == 0)
                    flag_error($sformatf("unexpected item coef %0d expon %0d",
                                         coef_out, expon_out));
                else
                begin
                    want = sum_due.pop_front();
                    check_field("coef_out", int'(want.coef), int'(coef_out));
                    check_field("expon_out", int'(want.expon), int'(expon_out));
                    check_field("last_term", int'(want.last_term), int'(last_term));
                    check_field("zero_poly", int'(want.zero_poly), int'(zero_poly));
                    check_field("terms_lost", int'(want.terms_lost), int'(terms_lost));
                end
            end
        end
    end

    initial
    begin : result_drain
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= no_gaps || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        action = ACT_LOAD_A;
        coef_in = 16'sd0;
        expon_in = 16'd0;
        fails = 0;
        no_gaps = 1'b0;
        rx_hold_req = 0;
        held_a = 0;
        held_b = 0;
        lost_loads = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_terms();
        test_store_overflow();
        test_backpressure();
        test_random_polys();

        @(negedge clk);
        push <= 1'b0;
        wait (sum_due.size() == 0);
        repeat (80) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sparse_polynomial_adder.f @@
hw/rtl/spa_pkg.sv
hw/rtl/spa_queue.sv
hw/rtl/spa_front.sv
hw/rtl/spa_back.sv
hw/rtl/sparse_polynomial_adder.sv
tb/tb_sparse_polynomial_adder.sv
